>>> src/aes_variant_block_cipher_core_assert.svh
// ----------------------------------------------------------------------------
// aes_variant_block_cipher_core_assert.svh
// assertion macros for the cipher core, clocked on clk, reset by arst_n
// ----------------------------------------------------------------------------
`ifndef AES_VARIANT_BLOCK_CIPHER_CORE_ASSERT_SVH
`define AES_VARIANT_BLOCK_CIPHER_CORE_ASSERT_SVH

// same-cycle implication
`define AESV_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aesv assertion failed");

// next-cycle implication
`define AESV_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aesv assertion failed");

`endif

>>> src/aesv_pkg.sv
// ----------------------------------------------------------------------------
// aesv_pkg
// constants, tables and byte functions of the aes-128 variant cipher
// ----------------------------------------------------------------------------
package aesv_pkg;

	typedef logic [127:0] blk_t;
	typedef logic [1:0]   reg_idx_t;
	typedef logic [3:0]   kcnt_t;

	localparam reg_idx_t REG_KEY_HIGH = 2'd0;
	localparam reg_idx_t REG_KEY_LOW  = 2'd1;
	localparam logic     OP_ENCRYPT   = 1'b0;
	localparam kcnt_t    KCNT_IDLE    = 4'd0;
	localparam kcnt_t    KCNT_FIRST   = 4'd1;
	localparam kcnt_t    KCNT_LAST    = 4'd10;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [7:0] INV_ROW [4] = '{8'ha5, 8'h07, 8'h1a, 8'h73};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		gmul = p;
	endfunction

	function automatic logic [7:0] sub_fwd(input logic [7:0] x);
		sub_fwd = SBOX[xtime(x) ^ 8'h01];
	endfunction

	// undo s(2x+1): strip the 1, then halve in the field
	function automatic logic [7:0] sub_inv(input logic [7:0] y);
		logic [7:0] u;
		u = INV_SBOX[y] ^ 8'h01;
		sub_inv = u[0] ? ({1'b0, u[7:1]} ^ 8'h8d) : {1'b0, u[7:1]};
	endfunction

	function automatic logic [7:0] get_byte(input blk_t b, input int n);
		get_byte = b[127 - 8 * n -: 8];
	endfunction

	function automatic blk_t shift_rows(input blk_t b, input logic inverse);
		blk_t o;
		o = b;
		for (int r = 1; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				o[127 - 8 * (4 * c + r) -: 8] =
					get_byte(b, 4 * ((inverse ? (c + 4 - r) : (c + r)) % 4) + r);
			end
		end
		shift_rows = o;
	endfunction

	function automatic blk_t mix_fwd(input blk_t b);
		blk_t o;
		logic [7:0] s [4];
		logic [7:0] q [4];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				s[r] = get_byte(b, 4 * c + r);
				q[r] = gmul(s[r], 8'h04);
			end
			o[127 - 32 * c -: 32] = {s[0] ^ q[1] ^ q[2] ^ q[3] ^ s[3],
				q[0] ^ s[0] ^ s[1] ^ q[2] ^ q[3],
				q[0] ^ q[1] ^ s[1] ^ s[2] ^ q[3],
				q[0] ^ q[1] ^ q[2] ^ s[2] ^ s[3]};
		end
		mix_fwd = o;
	endfunction

	function automatic blk_t mix_inv(input blk_t b);
		blk_t o;
		logic [7:0] acc;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++) begin
					acc = acc ^ gmul(INV_ROW[(k - r + 4) % 4], get_byte(b, 4 * c + k));
				end
				o[127 - 8 * (4 * c + r) -: 8] = acc;
			end
		end
		mix_inv = o;
	endfunction

	function automatic blk_t key_next(input blk_t k, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
		t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		key_next = {w0, w1, w2, w3};
	endfunction

endpackage

>>> src/aesv_req_if.sv
// ----------------------------------------------------------------------------
// aesv_req_if
// request channel: operation and one 128-bit block
// ----------------------------------------------------------------------------
interface aesv_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [63:0] data_high;
	logic [63:0] data_low;

	modport source (output valid, operation, data_high, data_low, input ready);
	modport sink (input valid, operation, data_high, data_low, output ready);
endinterface

>>> src/aesv_rsp_if.sv
// ----------------------------------------------------------------------------
// aesv_rsp_if
// result channel: one 128-bit block
// ----------------------------------------------------------------------------
interface aesv_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;

	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

>>> src/aesv_cfg_if.sv
// ----------------------------------------------------------------------------
// aesv_cfg_if
// register write channel: index and write data
// ----------------------------------------------------------------------------
interface aesv_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/aesv_round.sv
// ----------------------------------------------------------------------------
// aesv_round
// one cipher round, forward or inverse, selected per block
// ----------------------------------------------------------------------------
module aesv_round (
	input  logic          op,
	input  logic          mix_en,
	input  aesv_pkg::blk_t blk,
	input  aesv_pkg::blk_t rk,
	output aesv_pkg::blk_t res
);
	import aesv_pkg::*;

	blk_t enc_sub;
	blk_t enc_sh;
	blk_t enc_out;
	blk_t dec_add;
	blk_t dec_mix;
	blk_t dec_sh;
	blk_t dec_out;

	always_comb begin
		for (int n = 0; n < 16; n++) begin
			enc_sub[127 - 8 * n -: 8] = sub_fwd(blk[127 - 8 * n -: 8]);
		end
		enc_sh  = shift_rows(enc_sub, 1'b0);
		enc_out = (mix_en ? mix_fwd(enc_sh) : enc_sh) ^ rk;

		dec_add = blk ^ rk;
		dec_mix = mix_en ? mix_inv(dec_add) : dec_add;
		dec_sh  = shift_rows(dec_mix, 1'b1);
		for (int n = 0; n < 16; n++) begin
			dec_out[127 - 8 * n -: 8] = sub_inv(dec_sh[127 - 8 * n -: 8]);
		end
	end

	assign res = (op == OP_ENCRYPT) ? enc_out : dec_out;
endmodule

>>> src/aes_variant_block_cipher_core.sv
// a taken request enters blk_s[0], then blk_s[1] to blk_s[10], one round per stage
// throughput: one block per cycle when rsp is ready and no keys are being built
// after reset and after each key write the round keys are built one per cycle into
// rk_q[1] to rk_q[10], and no request is taken meanwhile; reset clears keys to zero
// and empties the pipeline
// ----------------------------------------------------------------------------
// aes_variant_block_cipher_core
// pipelined aes-128 variant encrypt and decrypt with stored round keys
// ----------------------------------------------------------------------------
module aes_variant_block_cipher_core (
	input  logic       clk,
	input  logic       arst_n,
	aesv_req_if.sink   req,
	aesv_rsp_if.source rsp,
	aesv_cfg_if.sink   cfg
);
	import aesv_pkg::*;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	blk_t        kw_q;
	logic [7:0]  rc_q;
	kcnt_t       kcnt_q;
	blk_t        rk_q [1:10];
	blk_t        rk0;
	blk_t        key_nxt;

	logic        vld_s [0:10];
	logic        op_s  [0:10];
	blk_t        blk_s [0:10];
	blk_t        rnd_out [1:10];

	logic        advance;
	logic        cfg_wr;

	assign rk0     = {key_high_q, key_low_q};
	assign key_nxt = key_next(kw_q, rc_q);
	assign cfg_wr  = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	// key registers and round key build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			kw_q       <= '0;
			rc_q       <= 8'h01;
			kcnt_q     <= KCNT_FIRST;
		end else if (cfg_wr && (cfg.index == REG_KEY_HIGH || cfg.index == REG_KEY_LOW)) begin
			rc_q   <= 8'h01;
			kcnt_q <= KCNT_FIRST;
			if (cfg.index == REG_KEY_HIGH) begin
				key_high_q <= cfg.data;
				kw_q       <= {cfg.data, key_low_q};
			end else begin
				key_low_q <= cfg.data;
				kw_q      <= {key_high_q, cfg.data};
			end
		end else if (kcnt_q != KCNT_IDLE) begin
			kw_q   <= key_nxt;
			rc_q   <= xtime(rc_q);
			kcnt_q <= (kcnt_q == KCNT_LAST) ? KCNT_IDLE : kcnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i <= 10; i++) begin
			if (kcnt_q == 4'(i)) rk_q[i] <= key_nxt;
		end
	end

	// pipeline
	assign advance   = !vld_s[10] || rsp.ready;
	assign req.ready = advance && (kcnt_q == KCNT_IDLE);

	for (genvar g = 1; g <= 10; g++) begin : g_round
		aesv_round u_round (
			.op     (op_s[g-1]),
			.mix_en ((op_s[g-1] == OP_ENCRYPT) ? (g != 10) : (g != 1)),
			.blk    (blk_s[g-1]),
			.rk     ((op_s[g-1] == OP_ENCRYPT) ? rk_q[g] : rk_q[11-g]),
			.res    (rnd_out[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= 10; i++) vld_s[i] <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= req.valid && req.ready;
			for (int i = 1; i <= 10; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s[0]  <= req.operation;
			blk_s[0] <= {req.data_high, req.data_low} ^
				((req.operation == OP_ENCRYPT) ? rk0 : '0);
			for (int i = 1; i <= 10; i++) begin
				op_s[i]  <= op_s[i-1];
				blk_s[i] <= rnd_out[i];
			end
		end
	end

	assign rsp.valid = vld_s[10];
	assign {rsp.result_high, rsp.result_low} =
		blk_s[10] ^ ((op_s[10] == OP_ENCRYPT) ? '0 : rk0);

	`include "aes_variant_block_cipher_core_assert.svh"

	`AESV_ASSERT_NOW(a_no_req_while_keying, req.valid && req.ready, kcnt_q == KCNT_IDLE)
	`AESV_ASSERT_NEXT(a_key_write_restarts, cfg_wr && cfg.index == REG_KEY_LOW, kcnt_q == KCNT_FIRST)
	`AESV_ASSERT_NEXT(a_keying_ends, kcnt_q == KCNT_LAST && !cfg_wr, kcnt_q == KCNT_IDLE)
endmodule

>>> tb/aes_variant_block_cipher_core_tb.sv
// ----------------------------------------------------------------------------
// aes_variant_block_cipher_core_tb
// drives random and directed encrypt and decrypt requests with random idling on
// both channels, rewrites the key between phases, and checks every result block
// against a cycle-free software cipher built into the testbench
// ----------------------------------------------------------------------------
module aes_variant_block_cipher_core_tb;
	import aesv_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic        op;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        has_exp;
		logic [63:0] exp_hi;
		logic [63:0] exp_lo;
	} block_row_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_out_t;

	logic clk;
	logic arst_n;

	aesv_req_if req ();
	aesv_rsp_if rsp ();
	aesv_cfg_if cfg ();

	aes_variant_block_cipher_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source),
		.cfg   (cfg.sink)
	);

	logic [63:0]  key_hi_model;
	logic [63:0]  key_lo_model;
	logic [7:0]   byte_inv [256];
	cipher_out_t  pending_blocks [$];
	int           error_count;
	int           idle_cycles;
	int           blocks_sent;
	int           blocks_checked;
	int           decrypt_count;
	int           key_writes;
	bit           rsp_stall_on;
	bit           timed_out;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
		end
		return p;
	endfunction

	function automatic logic [7:0] byte_sub(input logic [7:0] x);
		logic [7:0] t;
		t = {x[6:0], 1'b1};
		if (x[7]) t ^= 8'h1b;
		return SBOX[t];
	endfunction

	// block as 16 bytes, byte n at bits 127-8n
	function automatic cipher_out_t cipher_block(input logic op, input logic [63:0] hi,
			input logic [63:0] lo);
		logic [7:0]  rk [11][16];
		logic [7:0]  w [44][4];
		logic [7:0]  t [4];
		logic [7:0]  f;
		logic [7:0]  b [16];
		logic [7:0]  c [16];
		logic [7:0]  rc;
		logic [127:0] kk;
		logic [127:0] d;
		logic [7:0]  inv_coef [4];
		cipher_out_t o;
		inv_coef = '{8'ha5, 8'h07, 8'h1a, 8'h73};
		kk = {key_hi_model, key_lo_model};
		d = {hi, lo};
		for (int i = 0; i < 16; i++) begin
			w[i / 4][i % 4] = kk[127 - 8 * i -: 8];
			b[i] = d[127 - 8 * i -: 8];
		end
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if (i % 4 == 0) begin
				f = t[0];
				t[0] = SBOX[t[1]] ^ rc;
				t[1] = SBOX[t[2]];
				t[2] = SBOX[t[3]];
				t[3] = SBOX[f];
				rc = rc[7] ? ({rc[6:0], 1'b0} ^ 8'h1b) : {rc[6:0], 1'b0};
			end
			for (int j = 0; j < 4; j++) w[i][j] = w[i - 4][j] ^ t[j];
		end
		for (int r = 0; r < 11; r++)
			for (int j = 0; j < 16; j++) rk[r][j] = w[4 * r + j / 4][j % 4];
		if (!op) begin
			for (int i = 0; i < 16; i++) b[i] ^= rk[0][i];
			for (int r = 1; r <= 10; r++) begin
				for (int i = 0; i < 16; i++) c[i] = byte_sub(b[i]);
				for (int i = 0; i < 16; i++) b[i] = c[4 * ((i / 4 + i % 4) % 4) + i % 4];
				if (r < 10) begin
					for (int col = 0; col < 4; col++) begin
						for (int i = 0; i < 4; i++) c[i] = b[4 * col + i];
						for (int i = 0; i < 4; i++)
							b[4 * col + i] = c[i] ^ gf_mul(c[(i + 1) % 4], 8'h04)
								^ gf_mul(c[(i + 2) % 4], 8'h04)
								^ gf_mul(c[(i + 3) % 4], 8'h05);
					end
				end
				for (int i = 0; i < 16; i++) b[i] ^= rk[r][i];
			end
		end else begin
			for (int r = 10; r >= 1; r--) begin
				for (int i = 0; i < 16; i++) b[i] ^= rk[r][i];
				if (r < 10) begin
					for (int col = 0; col < 4; col++) begin
						for (int i = 0; i < 4; i++) c[i] = b[4 * col + i];
						for (int i = 0; i < 4; i++) begin
							b[4 * col + i] = 8'h00;
							for (int k = 0; k < 4; k++)
								b[4 * col + i] ^= gf_mul(inv_coef[(k - i + 4) % 4], c[k]);
						end
					end
				end
				for (int i = 0; i < 16; i++) c[i] = b[i];
				for (int i = 0; i < 16; i++)
					b[i] = byte_inv[c[4 * ((i / 4 + 4 - i % 4) % 4) + i % 4]];
			end
			for (int i = 0; i < 16; i++) b[i] ^= rk[0][i];
		end
		for (int i = 0; i < 16; i++) d[127 - 8 * i -: 8] = b[i];
		o.hi = d[127:64];
		o.lo = d[63:0];
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, compare against oldest prediction
	always @(posedge clk) begin
		cipher_out_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_blocks.size() == 0) begin
				$error("unexpected result %h %h", rsp.result_high, rsp.result_low);
				error_count++;
			end else begin
				e = pending_blocks.pop_front();
				blocks_checked++;
				if (rsp.result_high !== e.hi) begin
					$error("result_high expected %h actual %h", e.hi, rsp.result_high);
					error_count++;
				end
				if (rsp.result_low !== e.lo) begin
					$error("result_low expected %h actual %h", e.lo, rsp.result_low);
					error_count++;
				end
			end
		end
		rsp.ready <= rsp_stall_on ? ($urandom_range(99) >= 15) : 1'b1;
	end

	// watchdog on cycles without any handshake on the request, result or register channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_key(input reg_idx_t idx, input logic [63:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_KEY_HIGH) key_hi_model = value;
		else if (idx == REG_KEY_LOW) key_lo_model = value;
		key_writes++;
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
			input bit gaps);
		while (gaps && $urandom_range(99) < 15) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.data_high <= hi;
		req.data_low  <= lo;
		do @(posedge clk); while (!req.ready);
		pending_blocks.push_back(cipher_block(op, hi, lo));
		blocks_sent++;
		if (op) decrypt_count++;
	endtask

	task automatic send_checked_row(input block_row_t row);
		cipher_out_t p;
		p = cipher_block(row.op, row.hi, row.lo);
		if (row.has_exp && (p.hi !== row.exp_hi || p.lo !== row.exp_lo)) begin
			$error("directed row mismatch: expected %h %h", row.exp_hi, row.exp_lo);
			error_count++;
		end
		send_block(row.op, row.hi, row.lo, 1'b1);
	endtask

	block_row_t directed_rows [$];

	initial begin
		block_row_t row;
		cipher_out_t ct;
		logic [63:0] rh;
		logic [63:0] rl;
		error_count = 0;
		blocks_sent = 0;
		blocks_checked = 0;
		decrypt_count = 0;
		key_writes = 0;
		timed_out = 1'b0;
		idle_cycles = 0;
		rsp_stall_on = 1'b1;
		key_hi_model = '0;
		key_lo_model = '0;
		for (int v = 0; v < 256; v++) byte_inv[byte_sub(v[7:0])] = v[7:0];
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_ENCRYPT;
		req.data_high = '0;
		req.data_low = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_KEY_HIGH;
		cfg.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero key after reset, field extremes, both operations
		directed_rows = '{
			'{1'b0, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
			'{1'b1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
			'{1'b0, '1, '1, 1'b0, 64'h0, 64'h0},
			'{1'b1, '1, '1, 1'b0, 64'h0, 64'h0},
			'{1'b0, 64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0},
			'{1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0},
			'{1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0},
			'{1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0}
		};
		foreach (directed_rows[i]) send_checked_row(directed_rows[i]);
		wait_drained();
		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		foreach (directed_rows[i]) send_checked_row(directed_rows[i]);
		wait_drained();
		// out-of-range index leaves the key alone
		write_key(reg_idx_t'(2), 64'h1234);
		write_key(reg_idx_t'(3), 64'h5678);
		write_key(REG_KEY_HIGH, 64'h000102030405060a);
		write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		// round trip: decrypt of an encryption gives the plaintext back
		ct = cipher_block(1'b0, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
		row = '{1'b1, ct.hi, ct.lo, 1'b1, 64'h00112233_44556677, 64'h8899aabb_ccddeeff};
		send_checked_row(row);
		for (int i = 0; i < 6; i++)
			send_block(i[0], 64'h1 << (i * 11), 64'h1 << (63 - i * 9), 1'b0);
		wait_drained();

		// random phases with a fresh key each
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_key(REG_KEY_HIGH, '0);
					write_key(REG_KEY_LOW, '1);
				end
				1: begin
					write_key(REG_KEY_HIGH, '1);
					write_key(REG_KEY_LOW, '0);
				end
				default: begin
					write_key(REG_KEY_HIGH, {$urandom, $urandom});
					write_key(REG_KEY_LOW, {$urandom, $urandom});
				end
			endcase
			rsp_stall_on = (ph != 3);
			for (int i = 0; i < 80; i++) begin
				rh = {$urandom, $urandom};
				rl = {$urandom, $urandom};
				if (i % 20 == 7 && ph == 4) begin
					req.valid <= 1'b0;
					do @(posedge clk); while (pending_blocks.size() != 0);
				end
				send_block(1'($urandom_range(1)), rh, rl, ph != 3);
			end
			wait_drained();
		end
		rsp_stall_on = 1'b1;

		wait_drained();
		$display("covered %0d blocks (%0d decrypt), %0d key writes, %0d results checked",
			blocks_sent, decrypt_count, key_writes, blocks_checked);
		$display("phases used zero, all-ones and random keys with stalls on both channels");
		if (error_count == 0 && pending_blocks.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> aes_variant_block_cipher_core.f
+incdir+src
src/aesv_pkg.sv
src/aesv_req_if.sv
src/aesv_rsp_if.sv
src/aesv_cfg_if.sv
src/aesv_round.sv
src/aes_variant_block_cipher_core.sv
tb/aes_variant_block_cipher_core_tb.sv
